// File: src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Chaining state after reset and after each finished message
    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;

    localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
    // First byte position of the length field
    localparam logic [5:0] MD5_LEN_POS  = 6'd56;
    localparam logic [5:0] MD5_POS_LAST = 6'd63;
    localparam logic [5:0] MD5_RND_LAST = 6'd63;

    // Per-round additive constants
    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {phase, round[1:0]}
    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_LENBLK,
        ST_DONE
    } md5_state_t;

    // Content of the block being compressed
    typedef enum logic [1:0] {
        BLK_FULL,   // 64 message bytes
        BLK_PAD,    // message tail, pad byte, zeros; no length
        BLK_LAST,   // message tail, pad byte, zeros, length
        BLK_LEN     // zeros and length only
    } md5_blk_t;

    // Controller to datapath
    typedef struct packed {
        logic     byte_wr;
        logic     start;
        logic     round_en;
        logic     chain_add;
        logic     out_load;
        logic     restart;
        md5_blk_t mode;
    } md5_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [5:0] pos;
        logic       pos_hi;
        logic       last_round;
        logic       out_busy;
    } md5_sts_t;

endpackage

// File: src/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, block compression, padding and digest hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl
    import md5_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_byte_present,
    input  logic     s_end_of_message,
    input  md5_sts_t sts,
    output md5_cmd_t cmd
);

    md5_state_t state_reg, state_next;
    md5_blk_t   mode_reg, mode_next;
    logic       eom_pend_reg, eom_pend_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= BLK_FULL;
            eom_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            eom_pend_reg <= eom_pend_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        eom_pend_next = eom_pend_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.mode      = mode_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.byte_wr = s_byte_present;
                    if (s_byte_present && (sts.pos == MD5_POS_LAST)) begin
                        // buffer fills with this byte
                        cmd.start     = 1'b1;
                        mode_next     = BLK_FULL;
                        eom_pend_next = s_end_of_message;
                        state_next    = ST_COMP;
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // tail block; BLK_PAD when the tail is too long for the length field
                cmd.start     = 1'b1;
                mode_next     = sts.pos_hi ? BLK_PAD : BLK_LAST;
                eom_pend_next = 1'b0;
                state_next    = ST_COMP;
            end
            ST_COMP: begin
                cmd.round_en = 1'b1;
                if (sts.last_round) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                unique case (mode_reg)
                    BLK_FULL: state_next = eom_pend_reg ? ST_PAD : ST_IDLE;
                    BLK_PAD:  state_next = ST_LENBLK;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_LENBLK: begin
                cmd.start  = 1'b1;
                mode_next  = BLK_LEN;
                state_next = ST_COMP;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/md5_dp.sv
// ----------------------------------------------------------------------------
// md5_dp
// Datapath: block buffer, byte counter, round unit, chaining state and
// the digest output register.
// ----------------------------------------------------------------------------
module md5_dp
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  md5_cmd_t    cmd,
    output md5_sts_t    sts,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);

    // Block buffer as 16 little-endian words
    logic [31:0] wbuf_reg [16];
    // Message length in bytes; bit length is this shifted by three
    logic [60:0] cnt_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] dig_reg [4];
    logic [1:0]  oidx_reg;
    logic        ovld_reg;

    logic [5:0]  pos;
    logic [1:0]  phase;
    logic [3:0]  g;
    logic [6:0]  lim;
    logic        mark_en;
    logic        len_en;
    logic [63:0] len_bits;
    logic [31:0] w;
    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] t_dbl;
    logic [31:0] rot;

    assign pos      = cnt_reg[5:0];
    assign len_bits = {cnt_reg, 3'b000};

    assign sts.pos        = pos;
    assign sts.pos_hi     = (pos >= MD5_LEN_POS);
    assign sts.last_round = (rnd_reg == MD5_RND_LAST);
    assign sts.out_busy   = ovld_reg;

    // Block content limits for the current mode
    always_comb begin
        unique case (cmd.mode)
            BLK_FULL: begin lim = 7'd64;         mark_en = 1'b0; len_en = 1'b0; end
            BLK_PAD:  begin lim = {1'b0, pos};   mark_en = 1'b1; len_en = 1'b0; end
            BLK_LAST: begin lim = {1'b0, pos};   mark_en = 1'b1; len_en = 1'b1; end
            default:  begin lim = 7'd0;          mark_en = 1'b0; len_en = 1'b1; end
        endcase
    end

    // Message word index for this round
    assign phase = rnd_reg[5:4];
    always_comb begin
        unique case (phase)
            2'd0:    g = rnd_reg[3:0];
            2'd1:    g = 4'(rnd_reg[3:0] * 4'd5 + 4'd1);
            2'd2:    g = 4'(rnd_reg[3:0] * 4'd3 + 4'd5);
            default: g = 4'(rnd_reg[3:0] * 4'd7);
        endcase
    end

    // Word fetch with padding and length folded in
    always_comb begin
        logic [5:0] p;
        for (int j = 0; j < 4; j++) begin
            p = {g, 2'(j)};
            if ({1'b0, p} < lim) begin
                w[8*j +: 8] = wbuf_reg[g][8*j +: 8];
            end else if (mark_en && ({1'b0, p} == lim)) begin
                w[8*j +: 8] = MD5_PAD_BYTE;
            end else if (len_en && (p >= MD5_LEN_POS)) begin
                w[8*j +: 8] = len_bits[8*p[2:0] +: 8];
            end else begin
                w[8*j +: 8] = 8'h00;
            end
        end
    end

    // Round function
    always_comb begin
        unique case (phase)
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign t     = a_reg + f + w + MD5_K[rnd_reg];
    assign t_dbl = {t, t} << MD5_ROT[{phase, rnd_reg[1:0]}];
    assign rot   = t_dbl[63:32];

    // Buffer writes
    always_ff @(posedge aclk) begin
        if (cmd.byte_wr) begin
            wbuf_reg[pos[5:2]][8*pos[1:0] +: 8] <= s_data_byte;
        end
    end

    // Byte counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.restart) begin
            cnt_reg <= '0;
        end else if (cmd.byte_wr) begin
            cnt_reg <= cnt_reg + 61'd1;
        end
    end

    // Working variables and round counter
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            a_reg   <= chain_reg[0];
            b_reg   <= chain_reg[1];
            c_reg   <= chain_reg[2];
            d_reg   <= chain_reg[3];
            rnd_reg <= '0;
        end else if (cmd.round_en) begin
            a_reg   <= d_reg;
            d_reg   <= c_reg;
            c_reg   <= b_reg;
            b_reg   <= b_reg + rot;
            rnd_reg <= rnd_reg + 6'd1;
        end
    end

    // Chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            chain_reg[0] <= MD5_INIT_A;
            chain_reg[1] <= MD5_INIT_B;
            chain_reg[2] <= MD5_INIT_C;
            chain_reg[3] <= MD5_INIT_D;
        end else if (cmd.chain_add) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    // Digest output register, four beats
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            dig_reg <= chain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
            oidx_reg <= '0;
        end else if (cmd.out_load) begin
            ovld_reg <= 1'b1;
            oidx_reg <= '0;
        end else if (ovld_reg && m_ready) begin
            oidx_reg <= oidx_reg + 2'd1;
            if (oidx_reg == 2'd3) begin
                ovld_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = ovld_reg;
    assign m_digest_word = dig_reg[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 2'd3);

endmodule

// File: src/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 hash of a byte stream; digest returned as four little-endian words.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | beat
//  ---------+------------------------------------------------+-------------------
//  input    | s_valid s_ready s_data_byte s_byte_present     | one message byte
//           | s_end_of_message                               | and/or message end
//  output   | m_valid m_ready m_digest_word m_word_index     | one digest word
//           | m_last_word                                    |
//
// A byte beat is taken while the engine is idle; the byte that fills a 64-byte
// block starts a load, 64 rounds of the single round unit and a chaining add.
// An end beat adds a final block, or two when the tail leaves no room for
// the length field, and then a hand-off of the digest.
// The four digest beats drain from an output register while the next
// message is taken in; a second digest waits only if that register is full.
// Reset is synchronous, active low; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module md5_digest_engine
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);

    md5_cmd_t cmd;
    md5_sts_t sts;

    // Sequencer
    md5_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .sts              (sts),
        .cmd              (cmd)
    );

    // Datapath
    md5_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule
